// File: rtl/periodic_task_tick_scheduler_core_assert.svh
// Assertion macros for the periodic task tick scheduler.
// Expects clk_i and rst_ni in the scope of the including module; no other dependencies.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_CORE_ASSERT_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTTS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ptts: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PTTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ptts: next-cycle check failed");

`endif

// File: rtl/ptts_pkg.sv
// Shared types and constants for the periodic task tick scheduler.
// No dependencies; used by the scheduler core.
package ptts_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned SLOT_W  = 4;
  // At most this many fire words are reported for one tick.
  localparam int unsigned MAX_OUT = 16;
  localparam int unsigned CNT_W   = 5;

  typedef enum logic [KIND_W-1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_DELETE = 2'd2,
    OP_MODIFY = 2'd3
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    RES_FIRED      = 2'd0,
    RES_ADDED      = 2'd1,
    RES_FULL       = 2'd2,
    RES_OLD_PERIOD = 2'd3
  } res_e;

  // One entry of the slot table memory.
  typedef struct packed {
    logic [WORD_W-1:0] period;
    logic [WORD_W-1:0] countdown;
  } slot_word_t;

endpackage

// File: rtl/ptts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the scheduler's slot table.
module ptts_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/periodic_task_tick_scheduler_core.sv
// Periodic task tick scheduler: slot table walked by one shared countdown unit.
// Depends on ptts_pkg, ptts_ram and periodic_task_tick_scheduler_core_assert.svh.
//
//   Channel   Direction  Handshake          Payload
//   command   in         start / busy       kind_i, slot_i, period_i, first_delay_i
//   result    out        valid_o (strobe)   result_kind_o, result_slot_o, old_period_o, last_o
//
// A tick walks the whole table, reading one table entry per cycle from the slot table
// RAM, whose registered read puts the update in the cycle after the address.
// An add scans the slots in order for the lowest free one and reports full when none is
// free; a modify reads the slot, then writes it, and a delete only clears its flags.
// Reset empties the table at once through per-slot occupied and period-valid flags, so
// no clearing pass is needed. Result words are strobed for a single cycle and cannot be
// held off by the receiver.
`include "periodic_task_tick_scheduler_core_assert.svh"

module periodic_task_tick_scheduler_core #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [ptts_pkg::KIND_W-1:0]   kind_i,
  input  logic [ptts_pkg::SLOT_W-1:0]   slot_i,
  input  logic [ptts_pkg::WORD_W-1:0]   period_i,
  input  logic [ptts_pkg::WORD_W-1:0]   first_delay_i,
  output logic                          valid_o,
  output logic [ptts_pkg::KIND_W-1:0]   result_kind_o,
  output logic [ptts_pkg::SLOT_W-1:0]   result_slot_o,
  output logic [ptts_pkg::WORD_W-1:0]   old_period_o,
  output logic                          last_o
);

  localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam logic [IW-1:0] IDX_LAST = IW'(MAX_TASKS - 1);
  localparam int unsigned CNT_W = ptts_pkg::CNT_W;
  localparam int unsigned WORD_W = ptts_pkg::WORD_W;
  localparam int unsigned SLOT_W = ptts_pkg::SLOT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_ADD,
    ST_DEL,
    ST_MOD_RD,
    ST_MOD_WR
  } state_e;

  // Control state.
  state_e               state_q, state_d;
  logic [MAX_TASKS-1:0] used_q, used_d;
  // A slot whose period flag is clear reads its period as zero.
  logic [MAX_TASKS-1:0] pvld_q, pvld_d;
  logic [IW-1:0]        idx_q, idx_d;
  logic                 rd_act_q, rd_act_d;
  logic                 ex_vld_q, ex_vld_d;
  logic [IW-1:0]        ex_idx_q, ex_idx_d;
  logic                 pend_vld_q, pend_vld_d;
  logic [SLOT_W-1:0]    pend_slot_q, pend_slot_d;
  logic [CNT_W-1:0]     fire_cnt_q, fire_cnt_d;
  logic                 out_vld_q, out_vld_d;

  // Captured command word and result payload.
  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [WORD_W-1:0]    per_q, per_d;
  logic [WORD_W-1:0]    dly_q, dly_d;
  ptts_pkg::res_e       out_kind_q, out_kind_d;
  logic [SLOT_W-1:0]    out_slot_q, out_slot_d;
  logic [WORD_W-1:0]    out_old_q, out_old_d;
  logic                 out_last_q, out_last_d;

  // Slot table memory.
  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [IW-1:0]        ram_raddr;
  ptts_pkg::slot_word_t ram_wdata;
  logic [2*WORD_W-1:0]  ram_rdata;
  ptts_pkg::slot_word_t rd_word;

  // The shared countdown unit: one zero test and one decrement.
  logic [WORD_W-1:0]    cd_dec;
  logic                 cd_zero;
  logic [WORD_W-1:0]    per_eff;

  logic [IW-1:0]        slot_idx;
  logic                 slot_ok;

  ptts_ram #(
    .WIDTH (2 * WORD_W),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_word  = ptts_pkg::slot_word_t'(ram_rdata);
  assign cd_dec   = rd_word.countdown - WORD_W'(1);
  assign cd_zero  = (rd_word.countdown == '0);
  assign per_eff  = pvld_q[ex_idx_q] ? rd_word.period : '0;
  assign slot_idx = IW'(slot_q);
  assign slot_ok  = (32'(slot_q) < 32'(MAX_TASKS));

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    pvld_d      = pvld_q;
    idx_d       = idx_q;
    rd_act_d    = rd_act_q;
    ex_vld_d    = ex_vld_q;
    ex_idx_d    = ex_idx_q;
    pend_vld_d  = pend_vld_q;
    pend_slot_d = pend_slot_q;
    fire_cnt_d  = fire_cnt_q;
    slot_d      = slot_q;
    per_d       = per_q;
    dly_d       = dly_q;
    out_vld_d   = 1'b0;
    out_kind_d  = out_kind_q;
    out_slot_d  = out_slot_q;
    out_old_d   = out_old_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_waddr   = ex_idx_q;
    ram_raddr   = idx_q;
    ram_wdata   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          slot_d     = slot_i;
          per_d      = period_i;
          dly_d      = first_delay_i;
          idx_d      = '0;
          rd_act_d   = 1'b1;
          ex_vld_d   = 1'b0;
          pend_vld_d = 1'b0;
          fire_cnt_d = '0;
          unique case (ptts_pkg::op_e'(kind_i))
            ptts_pkg::OP_TICK:   state_d = ST_TICK;
            ptts_pkg::OP_ADD:    state_d = ST_ADD;
            ptts_pkg::OP_DELETE: state_d = ST_DEL;
            ptts_pkg::OP_MODIFY: state_d = ST_MOD_RD;
            default:             state_d = ST_IDLE;
          endcase
        end
      end

      ST_TICK: begin
        // Read address runs one slot ahead of the update stage.
        ram_raddr = idx_q;
        ex_vld_d  = rd_act_q;
        ex_idx_d  = idx_q;
        if (rd_act_q) begin
          if (idx_q == IDX_LAST) begin
            rd_act_d = 1'b0;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
        if (ex_vld_q && used_q[ex_idx_q]) begin
          if (cd_zero) begin
            // The newest firing is held back so that the final one can carry last.
            if (fire_cnt_q < CNT_W'(ptts_pkg::MAX_OUT)) begin
              if (pend_vld_q) begin
                out_vld_d  = 1'b1;
                out_kind_d = ptts_pkg::RES_FIRED;
                out_slot_d = pend_slot_q;
                out_old_d  = '0;
                out_last_d = 1'b0;
              end
              pend_vld_d  = 1'b1;
              pend_slot_d = SLOT_W'(ex_idx_q);
              fire_cnt_d  = fire_cnt_q + CNT_W'(1);
            end
            if (per_eff == '0) begin
              used_d[ex_idx_q] = 1'b0;
              pvld_d[ex_idx_q] = 1'b0;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = '{period: per_eff, countdown: per_eff};
            end
          end else begin
            ram_we    = 1'b1;
            ram_wdata = '{period: per_eff, countdown: cd_dec};
          end
        end
        if (!rd_act_q && !ex_vld_q) begin
          if (pend_vld_q) begin
            out_vld_d  = 1'b1;
            out_kind_d = ptts_pkg::RES_FIRED;
            out_slot_d = pend_slot_q;
            out_old_d  = '0;
            out_last_d = 1'b1;
          end
          pend_vld_d = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      ST_ADD: begin
        // Scan for the lowest free slot, one per cycle.
        if (!used_q[idx_q]) begin
          ram_we         = 1'b1;
          ram_waddr      = idx_q;
          ram_wdata      = '{period: per_q, countdown: dly_q};
          used_d[idx_q]  = 1'b1;
          pvld_d[idx_q]  = 1'b1;
          out_vld_d      = 1'b1;
          out_kind_d     = ptts_pkg::RES_ADDED;
          out_slot_d     = SLOT_W'(idx_q);
          out_old_d      = '0;
          out_last_d     = 1'b1;
          state_d        = ST_IDLE;
        end else if (idx_q == IDX_LAST) begin
          out_vld_d  = 1'b1;
          out_kind_d = ptts_pkg::RES_FULL;
          out_slot_d = '0;
          out_old_d  = '0;
          out_last_d = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end

      ST_DEL: begin
        if (slot_ok) begin
          used_d[slot_idx] = 1'b0;
          pvld_d[slot_idx] = 1'b0;
        end
        state_d = ST_IDLE;
      end

      ST_MOD_RD: begin
        ram_raddr = slot_idx;
        state_d   = ST_MOD_WR;
      end

      ST_MOD_WR: begin
        out_vld_d  = 1'b1;
        out_kind_d = ptts_pkg::RES_OLD_PERIOD;
        out_slot_d = slot_q;
        out_old_d  = '0;
        out_last_d = 1'b1;
        if (slot_ok) begin
          out_old_d        = pvld_q[slot_idx] ? rd_word.period : '0;
          ram_we           = 1'b1;
          ram_waddr        = slot_idx;
          ram_wdata        = '{period: per_q, countdown: rd_word.countdown};
          pvld_d[slot_idx] = 1'b1;
        end
        state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      used_q     <= '0;
      pvld_q     <= '0;
      idx_q      <= '0;
      rd_act_q   <= 1'b0;
      ex_vld_q   <= 1'b0;
      ex_idx_q   <= '0;
      pend_vld_q <= 1'b0;
      fire_cnt_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      pvld_q     <= pvld_d;
      idx_q      <= idx_d;
      rd_act_q   <= rd_act_d;
      ex_vld_q   <= ex_vld_d;
      ex_idx_q   <= ex_idx_d;
      pend_vld_q <= pend_vld_d;
      fire_cnt_q <= fire_cnt_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    slot_q      <= slot_d;
    per_q       <= per_d;
    dly_q       <= dly_d;
    pend_slot_q <= pend_slot_d;
    out_kind_q  <= out_kind_d;
    out_slot_q  <= out_slot_d;
    out_old_q   <= out_old_d;
    out_last_q  <= out_last_d;
  end

  assign busy          = (state_q != ST_IDLE);
  assign valid_o       = out_vld_q;
  assign result_kind_o = out_kind_q;
  assign result_slot_o = out_slot_q;
  assign old_period_o  = out_old_q;
  assign last_o        = out_last_q;

  `PTTS_ASSERT_NEXT(a_start_makes_busy, start && !busy, busy)
  `PTTS_ASSERT_SAME(a_single_word_last, valid_o && (result_kind_o != ptts_pkg::RES_FIRED), last_o)
  `PTTS_ASSERT_SAME(a_old_only_modify, valid_o && (result_kind_o != ptts_pkg::RES_OLD_PERIOD), old_period_o == '0)
  `PTTS_ASSERT_SAME(a_fire_cap, 1'b1, fire_cnt_q <= CNT_W'(ptts_pkg::MAX_OUT))
  `PTTS_ASSERT_SAME(a_walk_rw_apart, (state_q == ST_TICK) && ram_we && rd_act_q, ram_waddr != ram_raddr)

endmodule

// File: tb/periodic_task_tick_scheduler_core_test.sv
// Self-checking testbench for periodic_task_tick_scheduler_core: a slot-table predictor,
// a scoreboard of awaited result words, and directed plus random command traffic.
// Depends on ptts_pkg and the scheduler core RTL only.
module periodic_task_tick_scheduler_core_test;
  import ptts_pkg::*;

  localparam int unsigned NUM_SLOTS = 16;
  // Cycles with neither a command nor a result word accepted before the run is abandoned.
  // This is many times the longest quiet stretch of a correct run.
  localparam int unsigned STALL_LIMIT = 1000;
  // Settling time after the last awaited word: covers a delete or a tick that produces
  // no word but may still be walking the table.
  localparam int unsigned DRAIN_CYCLES = 2 * (NUM_SLOTS + 3);
  localparam int unsigned RANDOM_ITEMS = 460;
  localparam logic [WORD_W-1:0] PERIOD_MAX = '1;

  // One result word as the scheduler should present it.
  typedef struct {
    res_e              kind;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] old_period;
    logic              is_last;
  } sched_word_t;

  // Scoreboard: keeps a shadow of the task table, works out the words each accepted
  // command should produce, and checks returned words against them in order.
  class sched_scoreboard;
    bit                used      [NUM_SLOTS];
    logic [WORD_W-1:0] period    [NUM_SLOTS];
    logic [WORD_W-1:0] countdown [NUM_SLOTS];
    sched_word_t       pending   [$];
    int unsigned       mismatches;

    function new();
      foreach (used[i]) begin
        used[i]      = 1'b0;
        period[i]    = '0;
        countdown[i] = '0;
      end
      mismatches = 0;
    endfunction

    function void note_command(op_e op, logic [SLOT_W-1:0] slot,
                               logic [WORD_W-1:0] per, logic [WORD_W-1:0] dly);
      sched_word_t fresh [$];
      sched_word_t w;
      int          free_slot;
      w.old_period = '0;
      w.is_last    = 1'b0;
      case (op)
        OP_TICK: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (used[i]) begin
              if (countdown[i] == '0) begin
                if (fresh.size() < MAX_OUT) begin
                  w.kind = RES_FIRED;
                  w.slot = SLOT_W'(i);
                  fresh.push_back(w);
                end
                if (period[i] == '0) begin
                  used[i] = 1'b0;
                end else begin
                  countdown[i] = period[i];
                end
              end else begin
                countdown[i] = countdown[i] - 1'b1;
              end
            end
          end
        end
        OP_ADD: begin
          free_slot = -1;
          for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!used[i]) free_slot = i;
          end
          if (free_slot < 0) begin
            w.kind = RES_FULL;
            w.slot = '0;
          end else begin
            used[free_slot]      = 1'b1;
            period[free_slot]    = per;
            countdown[free_slot] = dly;
            w.kind = RES_ADDED;
            w.slot = SLOT_W'(free_slot);
          end
          fresh.push_back(w);
        end
        OP_DELETE: begin
          used[slot]   = 1'b0;
          period[slot] = '0;
        end
        default: begin
          w.kind       = RES_OLD_PERIOD;
          w.slot       = slot;
          w.old_period = period[slot];
          period[slot] = per;
          fresh.push_back(w);
        end
      endcase
      if (fresh.size() > 0) fresh[fresh.size() - 1].is_last = 1'b1;
      foreach (fresh[k]) pending.push_back(fresh[k]);
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_word(res_e kind, logic [SLOT_W-1:0] slot, logic [WORD_W-1:0] old_period,
                    logic is_last);
      sched_word_t w;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word kind %0d slot %0d", kind, slot));
      end else begin
        w = pending.pop_front();
        if (kind !== w.kind)
          report($sformatf("kind %0d, wanted %0d", kind, w.kind));
        if (slot !== w.slot)
          report($sformatf("slot %0d, wanted %0d", slot, w.slot));
        if (old_period !== w.old_period)
          report($sformatf("old period %h, wanted %h", old_period, w.old_period));
        if (is_last !== w.is_last)
          report($sformatf("last flag %b, wanted %b", is_last, w.is_last));
      end
    endtask
  endclass

  // Every input is given a known value from time zero.
  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              start         = 1'b0;
  logic [KIND_W-1:0] kind_i        = OP_TICK;
  logic [SLOT_W-1:0] slot_i        = '0;
  logic [WORD_W-1:0] period_i      = '0;
  logic [WORD_W-1:0] first_delay_i = '0;
  logic              busy;
  logic              valid_o;
  logic [KIND_W-1:0] result_kind_o;
  logic [SLOT_W-1:0] result_slot_o;
  logic [WORD_W-1:0] old_period_o;
  logic              last_o;

  sched_scoreboard sb = new();
  int unsigned     stall_cycles = 0;
  // While set, the sender issues commands back to back with no idle cycles.
  bit              quiet = 1'b0;

  periodic_task_tick_scheduler_core #(
    .MAX_TASKS(NUM_SLOTS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .kind_i       (kind_i),
    .slot_i       (slot_i),
    .period_i     (period_i),
    .first_delay_i(first_delay_i),
    .valid_o      (valid_o),
    .result_kind_o(result_kind_o),
    .result_slot_o(result_slot_o),
    .old_period_o (old_period_o),
    .last_o       (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Result words are strobed for a single cycle, so every strobed cycle is checked; the
  // values read here are those that stood before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1) begin
      sb.check_word(res_e'(result_kind_o), result_slot_o, old_period_o, last_o);
    end
  end

  // Watchdog: any accepted command or result word counts as progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && busy === 1'b0) || valid_o === 1'b1) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic int unsigned draw_gap();
    return quiet ? 0 : $urandom_range(0, 13);
  endfunction

  // Small values keep tasks firing often; now and then a full-width value exercises
  // every bit of the field.
  function automatic logic [WORD_W-1:0] draw_ticks();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return '0;
    if (pick < 85) return WORD_W'($urandom_range(1, 5));
    return $urandom();
  endfunction

  // Presents one command word after the drawn idle gap and returns at the edge that
  // accepts it. When the gap is zero, start simply stays high for the next word.
  task automatic send_command(op_e op, logic [SLOT_W-1:0] slot,
                              logic [WORD_W-1:0] per, logic [WORD_W-1:0] dly);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    kind_i        <= op;
    slot_i        <= slot;
    period_i      <= per;
    first_delay_i <= dly;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_command(op, slot, per, dly);
  endtask

  task automatic send_random_command();
    int unsigned pick;
    op_e         op;
    pick = $urandom_range(0, 99);
    if (pick < 40)      op = OP_TICK;
    else if (pick < 65) op = OP_ADD;
    else if (pick < 80) op = OP_DELETE;
    else                op = OP_MODIFY;
    send_command(op, SLOT_W'($urandom_range(0, NUM_SLOTS - 1)), draw_ticks(), draw_ticks());
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: a tick over the empty table, a one-shot task turned periodic by a
    // modify, a task with the largest period and delay, and modify of a free slot, which
    // still swaps the period while the slot stays free.
    send_command(OP_TICK, '0, '0, '0);
    send_command(OP_ADD, 4'd9, '0, '0);
    send_command(OP_ADD, 4'd3, PERIOD_MAX, PERIOD_MAX);
    send_command(OP_MODIFY, 4'd0, 32'd3, '0);
    send_command(OP_TICK, '0, '0, '0);
    send_command(OP_MODIFY, 4'd15, PERIOD_MAX, '0);
    send_command(OP_MODIFY, 4'd15, '0, PERIOD_MAX);
    // Deleting a free slot must pass without a word; then empty the table.
    send_command(OP_DELETE, 4'd7, '0, '0);
    send_command(OP_DELETE, 4'd0, '0, '0);
    send_command(OP_DELETE, 4'd1, '0, '0);
    // Fill every slot with a one-shot task due at once, overflow the table, then let one
    // tick fire all of them in a single burst of words, which also empties the table.
    for (int i = 0; i < NUM_SLOTS; i++) begin
      send_command(OP_ADD, SLOT_W'($urandom_range(0, NUM_SLOTS - 1)), '0, '0);
    end
    send_command(OP_ADD, '0, 32'd1, 32'd1);
    send_command(OP_TICK, '0, '0, '0);

    // Random traffic, alternating between stretches with idle gaps and stretches without.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) quiet = ($urandom_range(0, 2) == 0);
      send_random_command();
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
